// ===== hdl/finger_presence_detector_top_defines.svh =====
// Assertion macros shared by the finger presence detector RTL.
`ifndef FINGER_PRESENCE_DETECTOR_TOP_DEFINES_SVH
`define FINGER_PRESENCE_DETECTOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpd assertion failed");

// The condition must never be true.
`define FPD_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("fpd assertion failed");

`endif

// ===== hdl/fpd_pkg.sv =====
// Package with the constants and types of the finger presence detector.
package fpd_pkg;

   localparam int SAMPLE_BITS    = 18;
   localparam int REG_BITS       = 18;
   localparam int COUNT_BITS     = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 18;
   localparam int THR_BITS       = ((SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS) + 1;
   localparam int AVG_BITS       = SAMPLE_BITS + 3;
   localparam int FILL_BITS      = 8;

   localparam logic [FILL_BITS-1:0] FILL_LIMIT = 8'd200;

   localparam logic [REG_BITS-1:0]   OFFSET_UP_RESET     = 18'd9000;
   localparam logic [REG_BITS-1:0]   OFFSET_DOWN_RESET   = 18'd6000;
   localparam logic [REG_BITS-1:0]   BASELINE_GATE_RESET = 18'd4000;
   localparam logic [COUNT_BITS-1:0] CONFIRM_RESET       = 3'd3;
   localparam logic [COUNT_BITS-1:0] CAP_RESET           = 3'd5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_OFFSET_UP     = 3'd0,
      CSR_OFFSET_DOWN   = 3'd1,
      CSR_BASELINE_GATE = 3'd2,
      CSR_CONFIRM_COUNT = 3'd3,
      CSR_COUNT_CAP     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [REG_BITS-1:0]   offset_up;
      logic [REG_BITS-1:0]   offset_down;
      logic [REG_BITS-1:0]   baseline_gate;
      logic [COUNT_BITS-1:0] confirm_count;
      logic [COUNT_BITS-1:0] count_cap;
   } cfg_type;

   typedef struct packed {
      logic finger_present;
      logic presence_changed;
   } result_type;

endpackage

// ===== hdl/fpd_csr.sv =====
// Configuration registers of the finger presence detector.
module fpd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [fpd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fpd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output fpd_pkg::cfg_type                    cfg
);

   fpd_pkg::cfg_type cfg_ff;
   fpd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (fpd_pkg::csr_index_type'(csr_index))
            fpd_pkg::CSR_OFFSET_UP: begin
               cfg_in.offset_up = csr_wdata[fpd_pkg::REG_BITS-1:0];
            end
            fpd_pkg::CSR_OFFSET_DOWN: begin
               cfg_in.offset_down = csr_wdata[fpd_pkg::REG_BITS-1:0];
            end
            fpd_pkg::CSR_BASELINE_GATE: begin
               cfg_in.baseline_gate = csr_wdata[fpd_pkg::REG_BITS-1:0];
            end
            fpd_pkg::CSR_CONFIRM_COUNT: begin
               cfg_in.confirm_count = csr_wdata[fpd_pkg::COUNT_BITS-1:0];
            end
            fpd_pkg::CSR_COUNT_CAP: begin
               cfg_in.count_cap = csr_wdata[fpd_pkg::COUNT_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_up     <= fpd_pkg::OFFSET_UP_RESET;
         cfg_ff.offset_down   <= fpd_pkg::OFFSET_DOWN_RESET;
         cfg_ff.baseline_gate <= fpd_pkg::BASELINE_GATE_RESET;
         cfg_ff.confirm_count <= fpd_pkg::CONFIRM_RESET;
         cfg_ff.count_cap     <= fpd_pkg::CAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/fpd_core.sv =====
// Baseline tracker, confirmation counters and presence flag of the detector.
`include "finger_presence_detector_top_defines.svh"

module fpd_core (
   input  logic                             clock,
   input  logic                             reset,
   input  fpd_pkg::cfg_type                 cfg,
   input  logic                             step,
   input  logic [fpd_pkg::SAMPLE_BITS-1:0]  sample,
   output fpd_pkg::result_type              result
);

   logic [fpd_pkg::SAMPLE_BITS-1:0] baseline_ff, baseline_in;
   logic [fpd_pkg::FILL_BITS-1:0]   fill_ff, fill_in;
   logic [fpd_pkg::COUNT_BITS-1:0]  rise_ff, rise_in;
   logic [fpd_pkg::COUNT_BITS-1:0]  fall_ff, fall_in;
   logic                            present_ff, present_in;

   logic [fpd_pkg::THR_BITS-1:0]    sample_ext;
   logic [fpd_pkg::THR_BITS-1:0]    baseline_ext;
   logic [fpd_pkg::THR_BITS-1:0]    thr_up;
   logic [fpd_pkg::THR_BITS-1:0]    thr_low;
   logic [fpd_pkg::THR_BITS-1:0]    thr_gate;
   logic [fpd_pkg::AVG_BITS-1:0]    avg_sum;
   logic                            above;
   logic                            below;
   logic                            switch_on;
   logic                            present_mid;

   assign sample_ext   = fpd_pkg::THR_BITS'(sample);
   assign baseline_ext = fpd_pkg::THR_BITS'(baseline_ff);
   assign thr_up       = baseline_ext + fpd_pkg::THR_BITS'(cfg.offset_up);
   assign thr_low      = baseline_ext + fpd_pkg::THR_BITS'(cfg.offset_down);
   assign thr_gate     = baseline_ext + fpd_pkg::THR_BITS'(cfg.baseline_gate);
   assign above        = sample_ext > thr_up;
   assign below        = sample_ext < thr_low;

   // Seven eighths of the old baseline plus one eighth of the sample, rounded down.
   assign avg_sum = (fpd_pkg::AVG_BITS'(baseline_ff) << 3) - fpd_pkg::AVG_BITS'(baseline_ff)
                    + fpd_pkg::AVG_BITS'(sample);

   always_comb begin
      rise_in = rise_ff;
      fall_in = fall_ff;
      if (above) begin
         if (rise_ff < cfg.count_cap) begin
            rise_in = rise_ff + 3'd1;
         end
         fall_in = '0;
      end else if (below) begin
         if (fall_ff < cfg.count_cap) begin
            fall_in = fall_ff + 3'd1;
         end
         rise_in = '0;
      end
   end

   assign switch_on   = !present_ff && (rise_in >= cfg.confirm_count);
   assign present_mid = present_ff || switch_on;
   assign present_in  = present_mid && !(fall_in >= cfg.confirm_count);

   always_comb begin
      baseline_in = baseline_ff;
      fill_in     = fill_ff;
      if (!present_in) begin
         if (fill_ff == '0) begin
            baseline_in = sample;
         end else if (sample_ext < thr_gate) begin
            baseline_in = avg_sum[fpd_pkg::AVG_BITS-1:3];
         end
         if (fill_ff < fpd_pkg::FILL_LIMIT) begin
            fill_in = fill_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff <= '0;
         fill_ff     <= '0;
         rise_ff     <= '0;
         fall_ff     <= '0;
         present_ff  <= 1'b0;
      end else if (step) begin
         baseline_ff <= baseline_in;
         fill_ff     <= fill_in;
         rise_ff     <= rise_in;
         fall_ff     <= fall_in;
         present_ff  <= present_in;
      end
   end

   assign result.finger_present   = present_in;
   assign result.presence_changed = present_in != present_ff;

   `FPD_ASSERT_NEVER(a_counters_exclusive, clock, reset, (rise_ff != '0) && (fall_ff != '0))
   `FPD_ASSERT_NEXT(a_baseline_frozen, clock, reset, step && present_ff && present_in,
                    $stable(baseline_ff))
   `FPD_ASSERT_IMPLY(a_rise_confirmed, clock, reset, $rose(present_ff),
                     rise_ff >= $past(cfg.confirm_count))

endmodule

// ===== hdl/finger_presence_detector_top.sv =====
// Top level of the finger presence detector.
//
// The req_ channel carries one infrared sample per transaction; the rsp_ channel
// returns one transaction per sample with the presence flag after that sample and
// a flag that marks a change from the previous result. A transaction is taken on
// a rising edge where valid is high and stall is low on that channel.
// An accepted sample is held in an input register; once the output register is
// free, the baseline, counters and presence flag are updated while the result
// is loaded into the output register. While rsp_stall is low, one sample per
// cycle is sustained.
// When rsp_stall is high the output register holds its result, the input
// register keeps the next sample, and req_stall rises once both are full.
// The csr_ port writes one configuration register per cycle while csr_wr_en is high;
// the user must write it only while no transaction is in flight; the block does not enforce this.
// A synchronous reset empties both registers, loads the register defaults and
// clears the baseline, the counters and the presence flag (finger absent).
module finger_presence_detector_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fpd_pkg::SAMPLE_BITS-1:0]     req_ir_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_finger_present,
   output logic                                rsp_presence_changed,
   input  logic                                csr_wr_en,
   input  logic [fpd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fpd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   fpd_pkg::cfg_type                cfg;
   fpd_pkg::result_type             result;

   logic                            in_valid_ff, in_valid_in;
   logic [fpd_pkg::SAMPLE_BITS-1:0] in_sample_ff;
   logic                            out_valid_ff, out_valid_in;
   fpd_pkg::result_type             out_result_ff;
   logic                            out_free;
   logic                            step;
   logic                            accept;

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign step         = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_sample_ff <= req_ir_sample;
      end
      if (step) begin
         out_result_ff <= result;
      end
   end

   fpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fpd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .sample (in_sample_ff),
      .result (result)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_finger_present   = out_result_ff.finger_present;
   assign rsp_presence_changed = out_result_ff.presence_changed;

endmodule

// ===== dv/presence_predictor_pkg.sv =====
// Scoreboard class that predicts and checks the finger presence flags.
package presence_predictor_pkg;

   import fpd_pkg::*;

   class presence_predictor;
      cfg_type                 cfg;
      logic [SAMPLE_BITS-1:0]  baseline;
      logic [FILL_BITS-1:0]    fill;
      logic [COUNT_BITS-1:0]   rise_cnt;
      logic [COUNT_BITS-1:0]   fall_cnt;
      logic                    present;
      result_type              expected_flags[$];
      int unsigned             mismatches;
      int unsigned             samples_noted;
      int unsigned             flags_checked;
      int unsigned             switches_seen;

      function new();
         cfg.offset_up     = OFFSET_UP_RESET;
         cfg.offset_down   = OFFSET_DOWN_RESET;
         cfg.baseline_gate = BASELINE_GATE_RESET;
         cfg.confirm_count = CONFIRM_RESET;
         cfg.count_cap     = CAP_RESET;
         baseline      = '0;
         fill          = '0;
         rise_cnt      = '0;
         fall_cnt      = '0;
         present       = 1'b0;
         mismatches    = 0;
         samples_noted = 0;
         flags_checked = 0;
         switches_seen = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_OFFSET_UP:     cfg.offset_up     = value[REG_BITS-1:0];
            CSR_OFFSET_DOWN:   cfg.offset_down   = value[REG_BITS-1:0];
            CSR_BASELINE_GATE: cfg.baseline_gate = value[REG_BITS-1:0];
            CSR_CONFIRM_COUNT: cfg.confirm_count = value[COUNT_BITS-1:0];
            CSR_COUNT_CAP:     cfg.count_cap     = value[COUNT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SAMPLE_BITS-1:0] sample);
         logic [THR_BITS-1:0] thr_up;
         logic [THR_BITS-1:0] thr_low;
         logic [THR_BITS-1:0] thr_gate;
         logic [AVG_BITS:0]   avg;
         logic                prior_flag;
         result_type          flags;
         thr_up   = THR_BITS'(baseline) + THR_BITS'(cfg.offset_up);
         thr_low  = THR_BITS'(baseline) + THR_BITS'(cfg.offset_down);
         thr_gate = THR_BITS'(baseline) + THR_BITS'(cfg.baseline_gate);
         prior_flag = present;
         if (THR_BITS'(sample) > thr_up) begin
            if (rise_cnt < cfg.count_cap) rise_cnt = rise_cnt + 1'b1;
            fall_cnt = '0;
         end else if (THR_BITS'(sample) < thr_low) begin
            if (fall_cnt < cfg.count_cap) fall_cnt = fall_cnt + 1'b1;
            rise_cnt = '0;
         end
         if (!present && rise_cnt >= cfg.confirm_count) present = 1'b1;
         if (present && fall_cnt >= cfg.confirm_count) present = 1'b0;
         if (!present) begin
            if (fill == '0) begin
               baseline = sample;
            end else if (THR_BITS'(sample) < thr_gate) begin
               avg = (AVG_BITS+1)'(baseline) * (AVG_BITS+1)'(7) + (AVG_BITS+1)'(sample);
               baseline = avg[SAMPLE_BITS+2:3];
            end
            if (fill < FILL_LIMIT) fill = fill + 1'b1;
         end
         flags.finger_present   = present;
         flags.presence_changed = present ^ prior_flag;
         expected_flags.push_back(flags);
         samples_noted++;
      endfunction

      function void check_flags(logic finger_present, logic presence_changed);
         result_type want;
         if (expected_flags.size() == 0) begin
            $error("Unexpected result transaction: finger_present %0b, presence_changed %0b",
                   finger_present, presence_changed);
            mismatches++;
            return;
         end
         want = expected_flags.pop_front();
         flags_checked++;
         if (want.presence_changed) switches_seen++;
         if (finger_present !== want.finger_present) begin
            $error("finger_present: expected %0b, actual %0b",
                   want.finger_present, finger_present);
            mismatches++;
         end
         if (presence_changed !== want.presence_changed) begin
            $error("presence_changed: expected %0b, actual %0b",
                   want.presence_changed, presence_changed);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== dv/finger_presence_detector_top_test.sv =====
// Testbench top that drives the finger presence detector and checks its flags.
module finger_presence_detector_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   import fpd_pkg::*;
   import presence_predictor_pkg::*;

   localparam int          LIMIT_CYCLES = 200000;
   localparam int          SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
   localparam int          PHASE_ITEMS  = 140;

   typedef enum int {RUN_LOW, RUN_HIGH, RUN_MID, RUN_NOISE} run_kind_type;

   logic                      clock                = 1'b0;
   logic                      reset                = 1'b1;
   logic                      req_valid            = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_ir_sample        = '0;
   logic                      rsp_valid;
   logic                      rsp_stall            = 1'b0;
   logic                      rsp_finger_present;
   logic                      rsp_presence_changed;
   logic                      csr_wr_en            = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index            = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata            = '0;

   logic                      steady_flow          = 1'b0;
   int                        cycle_count          = 0;
   int                        settings_used        = 1;
   presence_predictor         pred                 = new();

   finger_presence_detector_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_ir_sample        (req_ir_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_finger_present   (rsp_finger_present),
      .rsp_presence_changed (rsp_presence_changed),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_ir_sample <= sample;
      do @(posedge clock); while (req_stall);
      pred.note_sample(sample);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pred.expected_flags.size() != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      pred.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic write_settings(input int up, input int down, input int gate,
                                 input int confirm, input int cap);
      logic [CSR_DATA_BITS-1:0] upper;
      drain_results();
      repeat (3) @(negedge clock);
      upper = $urandom_range(0, SAMPLE_MAX);
      write_reg(CSR_OFFSET_UP, CSR_DATA_BITS'(up));
      write_reg(CSR_OFFSET_DOWN, CSR_DATA_BITS'(down));
      write_reg(CSR_BASELINE_GATE, CSR_DATA_BITS'(gate));
      write_reg(CSR_CONFIRM_COUNT, {upper[CSR_DATA_BITS-1:COUNT_BITS], confirm[COUNT_BITS-1:0]});
      write_reg(CSR_COUNT_CAP, {upper[CSR_DATA_BITS-1:COUNT_BITS], cap[COUNT_BITS-1:0]});
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [SAMPLE_BITS-1:0] make_sample(run_kind_type kind);
      int base;
      int up;
      int down;
      int level;
      base = pred.baseline;
      up   = pred.cfg.offset_up;
      down = pred.cfg.offset_down;
      case (kind)
         RUN_LOW: begin
            level = base - int'($urandom_range(0, 3000));
            if (down > 0) level = level + int'($urandom_range(0, down - 1));
         end
         RUN_HIGH: level = base + up + 1 + int'($urandom_range(0, 20000));
         RUN_MID: begin
            level = base + down;
            if (up > down) level = level + int'($urandom_range(0, up - down));
         end
         default: level = int'($urandom_range(0, SAMPLE_MAX));
      endcase
      if (level < 0) level = 0;
      if (level > SAMPLE_MAX) level = SAMPLE_MAX;
      return level[SAMPLE_BITS-1:0];
   endfunction

   task automatic run_random(input int count);
      int           sent;
      int           len;
      int           pick;
      run_kind_type kind;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)      kind = RUN_LOW;
         else if (pick < 70) kind = RUN_HIGH;
         else if (pick < 80) kind = RUN_MID;
         else                kind = RUN_NOISE;
         len = $urandom_range(1, 9);
         steady_flow = ($urandom_range(0, 5) == 0);
         for (int i = 0; i < len && sent < count; i++) begin
            send_sample(make_sample(kind));
            sent++;
         end
         if ($urandom_range(0, 29) == 0) drain_results();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (1) begin
         int hold;
         hold = steady_flow ? 0 : $urandom_range(0, 3);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         pred.check_flags(rsp_finger_present, rsp_presence_changed);
         @(negedge clock);
      end
   end

   initial begin
      int up;
      int down;
      repeat (3) @(negedge clock);
      @(negedge clock);

      // Default settings: first sample loads the baseline, then confirm, saturate and release.
      send_sample(18'd1000);
      send_sample(18'd0);
      repeat (3) send_sample(18'h3FFFF);
      repeat (4) send_sample(18'h3FFFF);
      send_sample(18'd8000);
      drain_results();
      send_sample(18'h2AAAA);
      send_sample(18'h15555);
      repeat (3) send_sample(18'd500);
      send_sample(18'd0);
      send_sample(18'h3FFFF);
      send_sample(18'd0);
      repeat (2) send_sample(18'h3FFFF);
      send_sample(18'd8000);
      send_sample(18'h3FFFF);
      repeat (3) send_sample(18'd0);

      write_settings(0, 0, 0, 1, 1);
      run_random(PHASE_ITEMS);

      write_settings(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 7, 7);
      repeat (4) send_sample(18'h3FFFF);
      run_random(PHASE_ITEMS);

      write_settings($urandom_range(0, 20000), $urandom_range(0, 20000),
                     $urandom_range(0, 10000), 0, 0);
      run_random(PHASE_ITEMS);

      write_settings(9000, 6000, 4000, 0, 3);
      run_random(PHASE_ITEMS);

      for (int phase = 0; phase < 4; phase++) begin
         up   = $urandom_range(0, 20000);
         down = (phase == 3) ? up + $urandom_range(0, 5000) : $urandom_range(0, up);
         write_settings(up, down, $urandom_range(0, 10000),
                        $urandom_range(1, 7), $urandom_range(1, 7));
         run_random(PHASE_ITEMS);
      end

      req_valid <= 1'b0;
      while (pred.expected_flags.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d samples under %0d register settings, with %0d presence switches.",
               pred.samples_noted, settings_used, pred.switches_seen);
      $display("%0d result transactions checked, %0d mismatches.",
               pred.flags_checked, pred.mismatches);
      if (pred.mismatches == 0 && pred.expected_flags.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
